// ----- rtl/wavhc_pkg.sv -----
// types, codes and constant tables shared by the wav header checker and gain blocks
package wavhc_pkg;

	localparam int unsigned HDR_BYTES = 44;
	localparam int unsigned POS_W     = 6;

	localparam logic [7:0] GAIN_RESET = 8'd10;

	localparam logic [1:0] ST_PLAYING  = 2'd0;
	localparam logic [1:0] ST_FINISHED = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;
	localparam logic [1:0] ST_SHORT    = 2'd3;

	localparam logic [POS_W-1:0] POS_LAST_HDR = POS_W'(HDR_BYTES - 1);
	localparam logic [POS_W-1:0] POS_DATA     = POS_W'(HDR_BYTES);

	localparam logic [POS_W-1:0] POS_FORMAT   = 6'd21;
	localparam logic [POS_W-1:0] POS_CHANNELS = 6'd23;
	localparam logic [POS_W-1:0] POS_RATE     = 6'd27;
	localparam logic [POS_W-1:0] POS_BITS     = 6'd35;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_end;
	} wavhc_in_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               has_sample;
		logic [1:0]         status;
		logic               end_of_stream;
	} wavhc_out_t;

	typedef struct packed {
		logic        emit;
		logic        has_sample;
		logic [1:0]  status;
		logic        end_of_stream;
		logic [15:0] raw;
	} wavhc_ctl_t;

	typedef struct packed {
		logic       check;
		logic [7:0] value;
	} wavhc_marker_t;

	// expected marker byte at a header position
	function automatic wavhc_marker_t marker_at(input logic [POS_W-1:0] pos);
		wavhc_marker_t m;
		m.check = 1'b1;
		case (pos)
			6'd0:  m.value = "R";
			6'd1:  m.value = "I";
			6'd2:  m.value = "F";
			6'd3:  m.value = "F";
			6'd8:  m.value = "W";
			6'd9:  m.value = "A";
			6'd10: m.value = "V";
			6'd11: m.value = "E";
			6'd12: m.value = "f";
			6'd13: m.value = "m";
			6'd14: m.value = "t";
			6'd15: m.value = " ";
			6'd36: m.value = "d";
			6'd37: m.value = "a";
			6'd38: m.value = "t";
			6'd39: m.value = "a";
			default: begin
				m.check = 1'b0;
				m.value = 8'd0;
			end
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/wavhc_parse.sv -----
// per-file state: header position, header checks, sample pairing and result control
module wavhc_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  wavhc_pkg::wavhc_in_t item,
	output wavhc_pkg::wavhc_ctl_t ctl
);
	import wavhc_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d;
	logic             fault_q, fault_d;
	logic             phase_q, phase_d;
	logic             drop_q, drop_d;
	logic [23:0]      acc_q, acc_d;
	logic [7:0]       low_q, low_d;

	logic [7:0]    b;
	logic          last;
	logic [15:0]   half;
	logic [31:0]   word;
	logic          ok;
	logic          fault_n;
	wavhc_marker_t mk;

	assign b    = item.data_byte;
	assign last = item.file_end;
	assign half = {b, acc_q[23:16]};
	assign word = {b, acc_q};
	assign mk   = marker_at(pos_q);

	always_comb begin
		ok = 1'b1;
		if (mk.check) begin
			ok = (b == mk.value);
		end else if (pos_q == POS_FORMAT) begin
			ok = (half == 16'd1);
		end else if (pos_q == POS_CHANNELS) begin
			ok = (half == 16'd1) || (half == 16'd2);
		end else if (pos_q == POS_RATE) begin
			ok = (word == 32'd8000) || (word == 32'd16000) || (word == 32'd22050) ||
				(word == 32'd44100) || (word == 32'd48000);
		end else if (pos_q == POS_BITS) begin
			ok = (half == 16'd8) || (half == 16'd16) || (half == 16'd24) ||
				(half == 16'd32);
		end
	end

	assign fault_n = fault_q | ~ok;

	always_comb begin
		pos_d   = pos_q;
		fault_d = fault_q;
		phase_d = phase_q;
		drop_d  = drop_q;
		acc_d   = acc_q;
		low_d   = low_q;
		ctl     = '0;
		if (drop_q) begin
			if (last) begin
				drop_d = 1'b0;
				pos_d  = '0;
				fault_d = 1'b0;
				phase_d = 1'b0;
			end
		end else if (pos_q != POS_DATA) begin
			acc_d = {b, acc_q[23:8]};
			if (pos_q != POS_LAST_HDR) begin
				if (last) begin
					pos_d   = '0;
					fault_d = 1'b0;
					ctl.emit = 1'b1;
					ctl.status = ST_SHORT;
					ctl.end_of_stream = 1'b1;
				end else begin
					pos_d   = pos_q + 1'b1;
					fault_d = fault_n;
				end
			end else if (fault_n) begin
				ctl.emit = 1'b1;
				ctl.status = ST_REJECTED;
				ctl.end_of_stream = 1'b1;
				pos_d   = '0;
				fault_d = 1'b0;
				drop_d  = ~last;
			end else if (last) begin
				pos_d   = '0;
				fault_d = 1'b0;
				ctl.emit = 1'b1;
				ctl.status = ST_FINISHED;
				ctl.end_of_stream = 1'b1;
			end else begin
				pos_d = POS_DATA;
			end
		end else if (!phase_q) begin
			if (last) begin
				pos_d   = '0;
				fault_d = 1'b0;
				ctl.emit = 1'b1;
				ctl.status = ST_FINISHED;
				ctl.end_of_stream = 1'b1;
			end else begin
				low_d   = b;
				phase_d = 1'b1;
			end
		end else begin
			phase_d = 1'b0;
			ctl.emit = 1'b1;
			ctl.has_sample = 1'b1;
			ctl.raw = {b, low_q};
			ctl.status = last ? ST_FINISHED : ST_PLAYING;
			ctl.end_of_stream = last;
			if (last) begin
				pos_d   = '0;
				fault_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fault_q <= 1'b0;
			phase_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (en) begin
			pos_q   <= pos_d;
			fault_q <= fault_d;
			phase_q <= phase_d;
			drop_q  <= drop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_d;
			low_q <= low_d;
		end
	end

endmodule

// ----- rtl/wavhc_gain.sv -----
// sample times gain with saturation to int16
module wavhc_gain (
	input  logic [15:0]        raw,
	input  logic [7:0]         gain,
	output logic signed [15:0] sample
);
	import wavhc_pkg::*;

	logic signed [24:0] prod;

	assign prod = $signed(raw) * $signed({1'b0, gain});

	always_comb begin
		if (prod > 25'sd32767) begin
			sample = 16'sh7fff;
		end else if (prod < -25'sd32768) begin
			sample = 16'sh8000;
		end else begin
			sample = prod[15:0];
		end
	end

endmodule

// ----- rtl/wav_header_check_and_gain.sv -----
// top level: input register, header check and gain stage, result register
//
// Takes one byte of a WAV file per cycle and keeps taking one per cycle
// while results are drained. A byte sits in the input register, the header
// check or multiply-saturate runs in the single stage behind it, and any
// result is written to the result register as its byte leaves the input
// register. A result that waits holds the byte behind it in the input
// register, and the input then stalls until the result is taken. Header
// bytes of a good file give no result unless the file ends on the last
// one; a rejected header gives one and the rest of that file is dropped.
// Write gain through the cfg port only while no file bytes are in flight.
module wav_header_check_and_gain (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  wavhc_pkg::wavhc_in_t   item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output wavhc_pkg::wavhc_out_t  result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data
);
	import wavhc_pkg::*;

	logic [7:0] gain_val_q;
	wavhc_in_t  item_s1;
	logic       valid_s1;
	logic       advance;
	wavhc_ctl_t ctl;
	logic signed [15:0] amp;
	wavhc_out_t result_q;
	logic       result_valid_q;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 & (~result_valid_q | result_ready);
	assign item_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_val_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_val_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	wavhc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.ctl    (ctl)
	);

	wavhc_gain u_gain (
		.raw    (ctl.raw),
		.gain   (gain_val_q),
		.sample (amp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= ctl.emit;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.emit) begin
			result_q.sample        <= amp;
			result_q.has_sample    <= ctl.has_sample;
			result_q.status        <= ctl.status;
			result_q.end_of_stream <= ctl.end_of_stream;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- sim/wav_header_check_and_gain_tb.sv -----
// testbench for wav_header_check_and_gain: directed and random WAV files checked against a predictor
module wav_header_check_and_gain_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wavhc_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_BYTES  = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_PRINTED   = 40;
	localparam int SAT_HIGH      = 32767;
	localparam int SAT_LOW       = -32768;

	localparam logic [127:0] MARKER_TEXT = "RIFFWAVEfmt data";

	localparam logic [31:0] RATE_8K  = 32'd8000;
	localparam logic [31:0] RATE_16K = 32'd16000;
	localparam logic [31:0] RATE_22K = 32'd22050;
	localparam logic [31:0] RATE_44K = 32'd44100;
	localparam logic [31:0] RATE_48K = 32'd48000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	wavhc_in_t  item = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	wavhc_out_t result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	int cycle_count = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	bit send_paced = 1'b0;

	wavhc_out_t due_words[$];
	logic [7:0] file_q[$];

	// predictor state
	logic [7:0]  gain_setting = GAIN_RESET;
	logic [5:0]  hdr_pos = '0;
	bit          hdr_fault = 1'b0;
	logic [31:0] field_acc = '0;
	logic [7:0]  low_hold = '0;
	bit          want_high = 1'b0;
	bit          skipping = 1'b0;

	wav_header_check_and_gain dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("wav_header_check_and_gain verification failed");
		$finish;
	end

	function automatic logic [7:0] marker_char(input int idx);
		return MARKER_TEXT[8*(15-idx) +: 8];
	endfunction

	function automatic bit header_byte_ok(input logic [5:0] pos, input logic [7:0] b,
			input logic [31:0] acc);
		logic [15:0] half;
		half = acc[31:16];
		if (pos < 4)
			return b == marker_char(pos);
		if (pos >= 8 && pos < 16)
			return b == marker_char(pos - 4);
		if (pos >= 36 && pos < 40)
			return b == marker_char(pos - 24);
		case (pos)
			POS_FORMAT: return half == 16'd1;
			POS_CHANNELS: return half == 16'd1 || half == 16'd2;
			POS_RATE: return acc == RATE_8K || acc == RATE_16K || acc == RATE_22K ||
				acc == RATE_44K || acc == RATE_48K;
			POS_BITS: return half == 16'd8 || half == 16'd16 || half == 16'd24 ||
				half == 16'd32;
			default: return 1'b1;
		endcase
	endfunction

	task automatic clear_file_model();
		hdr_pos = '0;
		hdr_fault = 1'b0;
		field_acc = '0;
		low_hold = '0;
		want_high = 1'b0;
		skipping = 1'b0;
	endtask

	// header check and gain for one accepted byte
	task automatic model_wav_byte(input logic [7:0] b, input logic last);
		wavhc_out_t w;
		bit emit;
		int s16;
		int prod;
		w = '0;
		emit = 1'b0;
		if (skipping) begin
			if (last)
				clear_file_model();
		end else if (hdr_pos < HDR_BYTES) begin
			field_acc = {b, field_acc[31:8]};
			if (!header_byte_ok(hdr_pos, b, field_acc))
				hdr_fault = 1'b1;
			if (hdr_pos != POS_LAST_HDR) begin
				if (last) begin
					clear_file_model();
					emit = 1'b1;
					w.status = ST_SHORT;
					w.end_of_stream = 1'b1;
				end else begin
					hdr_pos = hdr_pos + 6'd1;
				end
			end else if (hdr_fault) begin
				if (last)
					clear_file_model();
				else
					skipping = 1'b1;
				emit = 1'b1;
				w.status = ST_REJECTED;
				w.end_of_stream = 1'b1;
			end else if (last) begin
				clear_file_model();
				emit = 1'b1;
				w.status = ST_FINISHED;
				w.end_of_stream = 1'b1;
			end else begin
				hdr_pos = POS_DATA;
			end
		end else if (!want_high) begin
			if (last) begin
				clear_file_model();
				emit = 1'b1;
				w.status = ST_FINISHED;
				w.end_of_stream = 1'b1;
			end else begin
				low_hold = b;
				want_high = 1'b1;
			end
		end else begin
			s16 = $signed({b, low_hold});
			prod = s16 * int'(gain_setting);
			if (prod > SAT_HIGH)
				prod = SAT_HIGH;
			else if (prod < SAT_LOW)
				prod = SAT_LOW;
			want_high = 1'b0;
			emit = 1'b1;
			w.sample = prod[15:0];
			w.has_sample = 1'b1;
			w.status = ST_PLAYING;
			if (last) begin
				clear_file_model();
				w.status = ST_FINISHED;
				w.end_of_stream = 1'b1;
			end
		end
		if (emit)
			due_words.push_back(w);
	endtask

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_word(input wavhc_out_t got);
		wavhc_out_t want;
		if (due_words.size() == 0) begin
			report($sformatf("unexpected word %h", got));
		end else begin
			want = due_words.pop_front();
			if (got.sample !== want.sample)
				report($sformatf("sample %h, want %h", got.sample, want.sample));
			if (got.has_sample !== want.has_sample)
				report($sformatf("has_sample %b, want %b", got.has_sample, want.has_sample));
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.end_of_stream !== want.end_of_stream)
				report($sformatf("end_of_stream %b, want %b", got.end_of_stream,
					want.end_of_stream));
		end
	endtask

	// result side: random stalls with calm stretches
	initial begin
		int stall;
		int stretch_left;
		bit take_paced;
		stretch_left = 0;
		take_paced = 1'b0;
		wait (arst_n);
		forever begin
			if (stretch_left == 0) begin
				take_paced = $urandom_range(0, 2) != 0;
				stretch_left = $urandom_range(1, 40);
			end
			stretch_left--;
			stall = take_paced ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			check_word(result);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = send_paced ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item.data_byte <= b;
		item.file_end <= last;
		do @(posedge clk); while (!item_ready);
		model_wav_byte(b, last);
		bytes_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only after drain_results
	task automatic write_gain(input logic [7:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_setting = g;
	endtask

	task automatic push_le(input logic [31:0] value, input int count);
		for (int i = 0; i < count; i++)
			file_q.push_back(value[8*i +: 8]);
	endtask

	task automatic push_marker(input int first);
		for (int i = 0; i < 4; i++)
			file_q.push_back(marker_char(first + i));
	endtask

	task automatic add_noise(input int count);
		for (int i = 0; i < count; i++)
			file_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_header(input logic [15:0] fmt, input logic [15:0] chans,
			input logic [31:0] rate, input logic [15:0] bits);
		file_q.delete();
		push_marker(0);
		push_le($urandom, 4);
		push_marker(4);
		push_marker(8);
		push_le($urandom, 4);
		push_le(fmt, 2);
		push_le(chans, 2);
		push_le(rate, 4);
		push_le($urandom, 4);
		push_le($urandom, 2);
		push_le(bits, 2);
		push_marker(12);
		push_le($urandom, 4);
	endtask

	task automatic truncate_file(input int len);
		while (file_q.size() > len)
			void'(file_q.pop_back());
	endtask

	task automatic send_file(input int pause_at);
		int n;
		n = file_q.size();
		send_paced = $urandom_range(0, 3) != 0;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain_results();
			send_byte(file_q[i], i == n - 1);
		end
	endtask

	function automatic logic [31:0] good_rate();
		case ($urandom_range(0, 4))
			0: return RATE_8K;
			1: return RATE_16K;
			2: return RATE_22K;
			3: return RATE_44K;
			default: return RATE_48K;
		endcase
	endfunction

	function automatic logic [15:0] good_bits();
		return 16'(8 * $urandom_range(1, 4));
	endfunction

	task automatic build_good_header();
		build_header(16'd1, 16'($urandom_range(1, 2)), good_rate(), good_bits());
	endtask

	task automatic test_short_files();
		file_q.delete();
		file_q.push_back(marker_char(0));
		send_file(-1);
		build_good_header();
		truncate_file(HDR_BYTES - 1);
		send_file(-1);
		build_good_header();
		file_q[0] = "X";
		truncate_file(20);
		send_file(-1);
	endtask

	task automatic test_header_only();
		build_good_header();
		send_file(-1);
		build_good_header();
		file_q[37] = "A";
		send_file(-1);
	endtask

	task automatic reject_case(input logic [15:0] fmt, input logic [15:0] chans,
			input logic [31:0] rate, input logic [15:0] bits, input int pos,
			input logic [7:0] value);
		build_header(fmt, chans, rate, bits);
		if (pos >= 0)
			file_q[pos] = value;
		add_noise(5);
		send_file(-1);
	endtask

	task automatic test_rejections();
		reject_case(16'd1, 16'd1, RATE_8K, 16'd8, 0, "X");
		reject_case(16'd1, 16'd1, RATE_8K, 16'd8, 11, "e");
		reject_case(16'd1, 16'd2, RATE_16K, 16'd16, 15, "_");
		reject_case(16'd1, 16'd2, RATE_16K, 16'd16, 39, "A");
		reject_case(16'd0, 16'd1, RATE_22K, 16'd24, -1, 8'h00);
		reject_case(16'h0101, 16'd1, RATE_22K, 16'd24, -1, 8'h00);
		reject_case(16'd1, 16'd0, RATE_44K, 16'd32, -1, 8'h00);
		reject_case(16'd1, 16'd3, RATE_44K, 16'd32, -1, 8'h00);
		reject_case(16'd1, 16'd2, 32'd44101, 16'd16, -1, 8'h00);
		reject_case(16'd1, 16'd2, RATE_8K + 32'h0001_0000, 16'd16, -1, 8'h00);
		reject_case(16'd1, 16'd2, RATE_48K, 16'd12, -1, 8'h00);
		reject_case(16'd1, 16'd2, RATE_48K, 16'h0110, -1, 8'h00);
	endtask

	task automatic test_good_formats();
		logic [31:0] rates [5];
		rates[0] = RATE_8K;
		rates[1] = RATE_16K;
		rates[2] = RATE_22K;
		rates[3] = RATE_44K;
		rates[4] = RATE_48K;
		for (int i = 0; i < 5; i++) begin
			build_header(16'd1, 16'(1 + i % 2), rates[i], 16'(8 * (1 + i % 4)));
			add_noise(4);
			send_file(-1);
		end
	endtask

	task automatic test_sample_extremes();
		logic [7:0] gains [4];
		gains[0] = GAIN_RESET;
		gains[1] = 8'd0;
		gains[2] = 8'd1;
		gains[3] = 8'd255;
		for (int g = 0; g < 4; g++) begin
			if (gains[g] != gain_setting) begin
				drain_results();
				write_gain(gains[g]);
			end
			build_header(16'd1, 16'd2, RATE_44K, 16'd16);
			push_le(16'h0000, 2);
			push_le(16'h0001, 2);
			push_le(16'h7FFF, 2);
			push_le(16'h8000, 2);
			push_le(16'hFFFF, 2);
			push_le(16'h0CCC, 2);
			push_le(16'h0CCD, 2);
			push_le(16'hF333, 2);
			push_le(16'hF334, 2);
			push_le(8'hA5, 1);
			send_file(-1);
		end
		// high byte of a sample is the file's last byte
		build_header(16'd1, 16'd1, RATE_8K, 16'd8);
		push_le(16'h8000, 2);
		send_file(-1);
	endtask

	task automatic test_pause_mid_file();
		build_good_header();
		add_noise(21);
		send_file(50);
		build_good_header();
		add_noise(8);
		send_file(20);
	endtask

	task automatic test_random_files();
		int start;
		int kind;
		int pause_at;
		logic [7:0] g;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: g = 8'd0;
					1: g = 8'd255;
					default: g = 8'($urandom_range(0, 255));
				endcase
				drain_results();
				write_gain(g);
			end
			kind = $urandom_range(0, 9);
			case (kind)
				6: begin
					build_good_header();
					file_q[$urandom_range(0, HDR_BYTES - 1)] ^= 8'($urandom_range(1, 255));
					add_noise($urandom_range(0, 20));
				end
				7: begin
					build_good_header();
					truncate_file($urandom_range(1, HDR_BYTES - 1));
				end
				8: begin
					file_q.delete();
					add_noise($urandom_range(1, 90));
				end
				9: begin
					build_header($urandom_range(0, 3) != 0 ? 16'd1 : 16'($urandom),
						16'($urandom_range(0, 3)),
						$urandom_range(0, 1) ? good_rate() : 32'($urandom_range(7990, 48010)),
						$urandom_range(0, 1) ? good_bits() : 16'($urandom_range(0, 40)));
					add_noise($urandom_range(0, 20));
				end
				default: begin
					build_good_header();
					add_noise($urandom_range(0, 3) == 0 ? $urandom_range(0, 120) :
						$urandom_range(0, 40));
				end
			endcase
			pause_at = $urandom_range(0, 15) == 0 ? $urandom_range(0, file_q.size() - 1) : -1;
			send_file(pause_at);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_files();
		test_header_only();
		test_rejections();
		test_good_formats();
		test_sample_extremes();
		test_pause_mid_file();
		test_random_files();
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("wav_header_check_and_gain verification clean");
		else
			$display("wav_header_check_and_gain verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/wavhc_pkg.sv
rtl/wavhc_parse.sv
rtl/wavhc_gain.sv
rtl/wav_header_check_and_gain.sv
sim/wav_header_check_and_gain_tb.sv
